[hdl/tcpds_pkg.sv]
`timescale 1ns / 1ps
// Package for the three-channel periodic due scheduler.
// Holds the sequencer state type, register indexes and reset periods; no dependencies.
package tcpds_pkg;

    localparam int unsigned GroupCount = 3;
    localparam int unsigned TimeWidth  = 64;
    localparam int unsigned AddrWidth  = 5;

    typedef logic [TimeWidth-1:0] t_time;
    typedef logic [1:0]           t_group;

    localparam t_group RegFastPeriod    = 2'd0;
    localparam t_group RegAirPeriod     = 2'd1;
    localparam t_group RegThermalPeriod = 2'd2;

    localparam t_time FastPeriodReset    = 64'd10000;
    localparam t_time AirPeriodReset     = 64'd20000;
    localparam t_time ThermalPeriodReset = 64'd100000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MASK,
        ST_SEL,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } t_state;

endpackage

[hdl/three_channel_periodic_due_scheduler_unit.sv]
`timescale 1ns / 1ps
// Top level of the three-channel periodic due scheduler: APB period registers,
// due-time compare, bit-serial remainder unit and output register. Uses tcpds_pkg.
// The first result passes one mask, one select, 64 remainder steps of one bit each and one final
// add after its timestamp is accepted; each further due group passes the select, remainder steps
// and final add again once the previous result is accepted.
// The 64-step restoring remainder loop does the division; a new timestamp is taken only when
// idle, so no new timestamp is taken until every due group of the last one has been output.
// Reset (synchronous, active low) sets all due times to zero and the periods to their defaults.
module three_channel_periodic_due_scheduler_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [tcpds_pkg::TimeWidth-1:0]     i_timestamp,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_group,
    output logic [tcpds_pkg::TimeWidth-1:0]     o_new_due,
    output logic                                o_last,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tcpds_pkg::AddrWidth-1:0]     paddr,
    input  logic [tcpds_pkg::TimeWidth-1:0]     pwdata,
    output logic [tcpds_pkg::TimeWidth-1:0]     prdata,
    output logic                                pready
);
    import tcpds_pkg::*;

    t_state r_state, n_state;
    t_time  r_period [GroupCount];
    t_time  r_due    [GroupCount];
    t_time  r_now;
    t_time  r_dvd;
    t_time  r_rem;
    t_time  r_per;
    t_time  r_new_due;
    t_group r_grp;
    logic   r_last;
    logic [GroupCount-1:0] r_mask;
    logic [5:0] r_cnt;

    t_group          w_widx;
    logic            w_wr;
    logic [TimeWidth:0] w_shift;
    logic            w_ge;
    logic [TimeWidth:0] w_sum;
    t_time           w_new_due;
    t_group          w_sel;
    logic [GroupCount-1:0] w_rest;

    assign pready = 1'b1;
    assign w_widx = paddr[AddrWidth-1:3];
    assign w_wr   = psel & penable & pwrite & pready;

    always_comb begin
        case (w_widx)
            RegFastPeriod:    prdata = r_period[0];
            RegAirPeriod:     prdata = r_period[1];
            RegThermalPeriod: prdata = r_period[2];
            default:          prdata = '0;
        endcase
    end

    assign w_shift   = {r_rem, r_dvd[TimeWidth-1]};
    assign w_ge      = w_shift >= {1'b0, r_per};
    assign w_sum     = {1'b0, r_now} - {1'b0, r_rem} + {1'b0, r_per};
    assign w_new_due = w_sum[TimeWidth] ? '1 : w_sum[TimeWidth-1:0];

    always_comb begin
        if (r_mask[0]) begin
            w_sel = 2'd0;
        end else if (r_mask[1]) begin
            w_sel = 2'd1;
        end else begin
            w_sel = 2'd2;
        end
        w_rest = r_mask & ~(GroupCount'(1) << w_sel);
    end

    assign o_ready   = (r_state == ST_IDLE);
    assign o_valid   = (r_state == ST_OUT);
    assign o_group   = r_grp;
    assign o_new_due = r_new_due;
    assign o_last    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_MASK;
                end
            end
            ST_MASK: n_state = ST_SEL;
            ST_SEL: begin
                if (r_mask == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == 6'd63) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: n_state = ST_OUT;
            ST_OUT: begin
                if (i_ready) begin
                    n_state = ST_SEL;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period[0] <= FastPeriodReset;
            r_period[1] <= AirPeriodReset;
            r_period[2] <= ThermalPeriodReset;
            for (int g = 0; g < GroupCount; g++) begin
                r_due[g] <= '0;
            end
            r_mask <= '0;
        end else begin
            if (w_wr && (w_widx != 2'd3)) begin
                r_period[w_widx] <= pwdata;
            end
            case (r_state)
                ST_MASK: begin
                    for (int g = 0; g < GroupCount; g++) begin
                        r_mask[g] <= (r_now >= r_due[g]);
                    end
                end
                ST_SEL: begin
                    if (r_mask != '0) begin
                        r_mask <= w_rest;
                    end
                end
                ST_FIN: begin
                    r_due[r_grp] <= w_new_due;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_now <= i_timestamp;
            end
            ST_SEL: begin
                r_grp  <= w_sel;
                r_last <= (w_rest == '0);
                r_dvd  <= r_now - r_due[w_sel];
                r_rem  <= '0;
                r_cnt  <= '0;
                r_per  <= (r_period[w_sel] == '0) ? t_time'(1) : r_period[w_sel];
            end
            ST_DIV: begin
                r_dvd <= {r_dvd[TimeWidth-2:0], 1'b0};
                r_rem <= w_ge ? t_time'(w_shift - {1'b0, r_per}) : w_shift[TimeWidth-1:0];
                r_cnt <= r_cnt + 6'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN) begin
            r_new_due <= w_new_due;
        end
    end

endmodule

[sim/tcpds_checker.sv]
`timescale 1ns / 1ps
// Checker for the three-channel periodic due scheduler: tracks period writes, predicts
// the due-group results of every accepted timestamp and compares them. Uses tcpds_pkg.
module tcpds_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                o_ready,
    input  logic [tcpds_pkg::TimeWidth-1:0]     i_timestamp,
    input  logic                                o_valid,
    input  logic                                i_ready,
    input  logic [1:0]                          o_group,
    input  logic [tcpds_pkg::TimeWidth-1:0]     o_new_due,
    input  logic                                o_last,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tcpds_pkg::AddrWidth-1:0]     paddr,
    input  logic [tcpds_pkg::TimeWidth-1:0]     pwdata,
    input  logic                                pready,
    output int                                  o_errors,
    output int                                  o_pending
);
    import tcpds_pkg::*;

    localparam t_time TimeMax = '1;

    typedef struct packed {
        t_group group;
        t_time  new_due;
        logic   last;
    } t_due_result;

    t_time       periods   [GroupCount];
    t_time       due_times [GroupCount];
    t_due_result due_queue [$];

    function automatic t_time next_due_after(input t_time due, input t_time period,
                                             input t_time stamp);
        t_time step;
        t_time missed;
        t_time room;
        step   = (period == '0) ? t_time'(1) : period;
        missed = (stamp - due) / step;
        room   = (TimeMax - due) / step;
        if (missed >= room) begin
            return TimeMax;
        end
        return due + (missed + t_time'(1)) * step;
    endfunction

    task automatic report_mismatch(input string what, input t_time got, input t_time want);
        $display("MISMATCH at %0t: %s, got %0h, expected %0h", $time, what, got, want);
        o_errors++;
    endtask

    task automatic queue_due_groups(input t_time stamp);
        logic [GroupCount-1:0] hit;
        int                    final_group;
        t_due_result           res;
        final_group = -1;
        for (int g = 0; g < GroupCount; g++) begin
            hit[g] = (stamp >= due_times[g]);
            if (hit[g]) begin
                final_group = g;
            end
        end
        for (int g = 0; g < GroupCount; g++) begin
            if (hit[g]) begin
                due_times[g] = next_due_after(due_times[g], periods[g], stamp);
                res.group    = t_group'(g);
                res.new_due  = due_times[g];
                res.last     = (g == final_group);
                due_queue.push_back(res);
            end
        end
    endtask

    task automatic check_due_result();
        t_due_result want;
        if (due_queue.size() == 0) begin
            report_mismatch("result with nothing expected", o_new_due, '0);
        end else begin
            want = due_queue.pop_front();
            if (o_group !== want.group) begin
                report_mismatch("group", t_time'(o_group), t_time'(want.group));
            end
            if (o_new_due !== want.new_due) begin
                report_mismatch("new_due", o_new_due, want.new_due);
            end
            if (o_last !== want.last) begin
                report_mismatch("last", t_time'(o_last), t_time'(want.last));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            periods[RegFastPeriod]    = FastPeriodReset;
            periods[RegAirPeriod]     = AirPeriodReset;
            periods[RegThermalPeriod] = ThermalPeriodReset;
            for (int g = 0; g < GroupCount; g++) begin
                due_times[g] = '0;
            end
            due_queue.delete();
        end else begin
            if (psel && penable && pwrite && pready && (paddr[4:3] < GroupCount)) begin
                periods[paddr[4:3]] = pwdata;
            end
            if (i_valid && o_ready) begin
                queue_due_groups(i_timestamp);
            end
            if (o_valid && i_ready) begin
                check_due_result();
            end
        end
        o_pending = due_queue.size();
    end

endmodule

[sim/three_channel_periodic_due_scheduler_unit_test.sv]
`timescale 1ns / 1ps
// Testbench top for the three-channel periodic due scheduler: clock, reset, APB period
// writes and timestamp stimulus. Uses tcpds_pkg, the block and tcpds_checker.
module three_channel_periodic_due_scheduler_unit_test;
    import tcpds_pkg::*;

    localparam t_time TimeMax   = '1;
    localparam int    RegUnused = 3;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    t_time                i_timestamp = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic [1:0]           o_group;
    t_time                o_new_due;
    logic                 o_last;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [AddrWidth-1:0] paddr       = '0;
    t_time                pwdata      = '0;
    t_time                prdata;
    logic                 pready;

    int    errors;
    int    pending;
    bit    calm;
    t_time stamp_walk;
    int    stamps_sent;
    int    settings_used;

    three_channel_periodic_due_scheduler_unit dut (.*);

    tcpds_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_timestamp, .o_valid, .i_ready,
        .o_group, .o_new_due, .o_last, .psel, .penable, .pwrite, .paddr, .pwdata,
        .pready, .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(0, 99) >= 34);
    end

    function automatic t_time rand_time();
        return {$urandom, $urandom};
    endfunction

    task automatic write_period(input int index, input t_time value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrWidth'(index * 8);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_periods(input t_time fast, input t_time air, input t_time thermal);
        write_period(int'(RegFastPeriod), fast);
        write_period(int'(RegAirPeriod), air);
        write_period(int'(RegThermalPeriod), thermal);
        settings_used++;
    endtask

    task automatic send_stamp(input t_time stamp);
        if (!calm) begin
            while ($urandom_range(0, 99) < 34) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid     <= 1'b1;
        i_timestamp <= stamp;
        do @(posedge i_clk); while (!o_ready);
        stamps_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // Mostly a rising time base with random steps; some transactions jump back in time.
    task automatic walk(input int count, input t_time max_step);
        t_time stamp;
        t_time jump;
        repeat (count) begin
            if ($urandom_range(0, 99) < 15) begin
                stamp = (stamp_walk == TimeMax) ? rand_time() : rand_time() % (stamp_walk + 1);
            end else begin
                jump = rand_time() % (max_step + 1);
                stamp_walk = (TimeMax - stamp_walk < jump) ? TimeMax : stamp_walk + jump;
                stamp = stamp_walk;
            end
            send_stamp(stamp);
        end
    endtask

    initial begin
        calm          = 1'b0;
        stamp_walk    = '0;
        stamps_sent   = 0;
        settings_used = 1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        send_stamp(64'd0);
        send_stamp(64'd0);
        send_stamp(64'd9999);
        send_stamp(64'd10000);
        send_stamp(64'd19999);
        send_stamp(64'd55555);
        send_stamp(64'd100000);
        send_stamp(64'd100001);
        stamp_walk = 64'd100001;
        drain();

        set_periods(64'd1, 64'd0, 64'd7);
        write_period(RegUnused, 64'd5);
        walk(30, 64'd20);
        drain();

        calm = 1'b1;
        set_periods(t_time'($urandom_range(1, 5000)), t_time'($urandom_range(1, 20000)),
                    t_time'($urandom_range(1, 100000)));
        walk(40, 64'd30000);
        drain();
        calm = 1'b0;

        set_periods(t_time'($urandom), rand_time() >> 24, rand_time() >> 16);
        walk(40, TimeMax >> 16);
        drain();

        set_periods(rand_time(), rand_time(), rand_time() >> 1);
        walk(40, TimeMax >> 4);
        drain();

        set_periods(TimeMax, 64'd1, rand_time() >> 8);
        walk(25, TimeMax >> 2);
        send_stamp(TimeMax - 1);
        send_stamp(TimeMax);
        send_stamp(TimeMax);
        send_stamp(TimeMax - 1);
        drain();

        set_periods(64'd0, TimeMax, 64'd3);
        send_stamp(64'd0);
        send_stamp(TimeMax);
        drain();

        $display("Sent %0d timestamps under %0d period settings, from zero up to saturation.",
                 stamps_sent, settings_used);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
